FILE: design/ctl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctl_pkg
// Shared types for the chunk tag locator: the input item, the register set
// and the register indexes of the configuration port.
// ----------------------------------------------------------------------------
package ctl_pkg;

  localparam int CfgIndexBits = 1;

  localparam logic [CfgIndexBits-1:0] CFG_TARGET_TAG   = 1'b0;
  localparam logic [CfgIndexBits-1:0] CFG_START_OFFSET = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] target_tag;
    logic [31:0] start_offset;
  } cfg_t;

endpackage
`default_nettype wire

FILE: design/ctl_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctl_in_stage
// Input register. Holds one item and hands it to the parser; takes a new
// item in the cycle the held one is consumed.
// ----------------------------------------------------------------------------
module ctl_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  input  wire logic          take,
  output ctl_pkg::item_t     item
);

  logic       held;
  logic [7:0] held_byte;
  logic       held_last;

  assign in_ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= data_byte;
      held_last <= last_byte;
    end
  end

  always_comb begin
    item.valid     = held;
    item.data_byte = held_byte;
    item.last_byte = held_last;
  end

endmodule
`default_nettype wire

FILE: design/ctl_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctl_parser
// Chunk walker and result register. Each taken item updates the scan state;
// a found or not-found answer is loaded into the result register.
// ----------------------------------------------------------------------------
module ctl_parser #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ctl_pkg::item_t item,
  input  wire ctl_pkg::cfg_t  cfg,
  output logic               take,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               found,
  output logic [31:0]        chunk_offset
);

  localparam int CmpBits = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

  localparam logic [2:0] PH_SKIP   = 3'd0;
  localparam logic [2:0] PH_SEARCH = 3'd1;
  localparam logic [2:0] PH_SIZE   = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_TAG    = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_Z   = 8'h5A;
  localparam logic [7:0] CHAR_TWO = 8'h32;
  localparam logic [7:0] CHAR_M   = 8'h4D;

  localparam logic [2:0] HDR_BYTES = 3'd4;

  function automatic logic tag_char(input logic [7:0] c);
    return (c inside {[CHAR_A:CHAR_Z]}) || (c == CHAR_TWO);
  endfunction

  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [2:0]             phase, phase_next;
  logic [31:0]            window, window_next;
  logic [31:0]            size_acc, size_acc_next;
  logic [31:0]            skip, skip_next;
  logic [2:0]             hdr_count, hdr_count_next;
  logic [OFFSET_BITS-1:0] chunk_start, chunk_start_next;

  logic        hit;
  logic        emit;
  logic [2:0]  ph;
  logic [31:0] shifted;
  logic [2:0]  hdr_inc;
  logic [31:0] skip_dec;
  logic [31:0] size_or;

  assign take = item.valid && (!out_valid || out_ready);

  always_comb begin
    shifted  = {window[23:0], item.data_byte};
    hdr_inc  = hdr_count + 3'd1;
    skip_dec = skip - {31'd0, (skip != 32'd0)};
    size_or  = size_acc | (32'(item.data_byte) << {hdr_count[1:0], 3'b000});

    ph = phase;
    if (phase == PH_SKIP && CmpBits'(pos) >= CmpBits'(cfg.start_offset)) begin
      ph = PH_SEARCH;
    end

    phase_next       = ph;
    window_next      = window;
    size_acc_next    = size_acc;
    skip_next        = skip;
    hdr_count_next   = hdr_count;
    chunk_start_next = chunk_start;
    hit              = 1'b0;

    case (ph)
      PH_SEARCH: begin
        window_next    = shifted;
        hdr_count_next = (hdr_count < HDR_BYTES) ? hdr_inc : hdr_count;
        if (hdr_count_next == HDR_BYTES && tag_char(shifted[31:24]) &&
            tag_char(shifted[23:16]) && tag_char(shifted[15:8]) &&
            shifted[7:0] == CHAR_M) begin
          chunk_start_next = pos - OFFSET_BITS'(3);
          hdr_count_next   = 3'd0;
          size_acc_next    = 32'd0;
          phase_next       = PH_SIZE;
          if (shifted == cfg.target_tag) begin
            phase_next = PH_DONE;
            hit        = 1'b1;
          end
        end
      end
      PH_SIZE: begin
        size_acc_next  = size_or;
        hdr_count_next = hdr_inc;
        if (hdr_inc >= HDR_BYTES) begin
          hdr_count_next = 3'd0;
          skip_next      = size_or;
          phase_next     = (size_or == 32'd0) ? PH_TAG : PH_BODY;
        end
      end
      PH_BODY: begin
        skip_next = skip_dec;
        if (skip_dec == 32'd0) begin
          hdr_count_next = 3'd0;
          phase_next     = PH_TAG;
        end
      end
      PH_TAG: begin
        if (hdr_count == 3'd0) begin
          chunk_start_next = pos;
        end
        window_next    = shifted;
        hdr_count_next = hdr_inc;
        if (hdr_inc >= HDR_BYTES) begin
          hdr_count_next = 3'd0;
          size_acc_next  = 32'd0;
          if (shifted == cfg.target_tag) begin
            phase_next = PH_DONE;
            hit        = 1'b1;
          end else begin
            phase_next = PH_SIZE;
          end
        end
      end
      default: begin
      end
    endcase

    pos_next = pos + OFFSET_BITS'(1);
    emit     = hit || (item.last_byte && phase_next != PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      phase       <= PH_SKIP;
      window      <= 32'd0;
      size_acc    <= 32'd0;
      skip        <= 32'd0;
      hdr_count   <= 3'd0;
      chunk_start <= '0;
    end else if (take) begin
      if (item.last_byte) begin
        pos         <= '0;
        phase       <= PH_SKIP;
        window      <= 32'd0;
        size_acc    <= 32'd0;
        skip        <= 32'd0;
        hdr_count   <= 3'd0;
        chunk_start <= '0;
      end else begin
        pos         <= pos_next;
        phase       <= phase_next;
        window      <= window_next;
        size_acc    <= size_acc_next;
        skip        <= skip_next;
        hdr_count   <= hdr_count_next;
        chunk_start <= chunk_start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      found        <= hit;
      chunk_offset <= hit ? 32'(chunk_start_next) : 32'd0;
    end
  end

endmodule
`default_nettype wire

FILE: design/chunk_tag_locator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_tag_locator
// Finds a tagged chunk in a byte stream of chunks and reports its offset.
//
// Input items carry one buffer byte each, with last_byte on the final byte.
// Bytes before start_offset are skipped, then a header of three tag chars
// (A-Z or '2') then 'M' is searched for, and the chunk chain walked from there.
// One result item is given per buffer: found with the chunk offset on the
// byte that completes the matching tag, or not found on the last byte.
// An item goes through an input register and the parser into the result
// register, and one item is accepted every cycle while the result side
// keeps up. When the receiver stalls, the result register holds and the
// input register fills, after which in_ready falls. Reset clears the valid
// flags, the configuration and the scan state; the scan state also returns
// to its reset value after each last byte.
// Configuration is written through cfg_write, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module chunk_tag_locator #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             found,
  output logic [31:0]      chunk_offset,
  input  wire logic        cfg_write,
  input  wire logic [ctl_pkg::CfgIndexBits-1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  ctl_pkg::cfg_t  cfg;
  ctl_pkg::item_t item;
  logic           take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_tag   <= 32'd0;
      cfg.start_offset <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        ctl_pkg::CFG_TARGET_TAG:   cfg.target_tag   <= cfg_data;
        ctl_pkg::CFG_START_OFFSET: cfg.start_offset <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ctl_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .take      (take),
    .item      (item)
  );

  ctl_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg          (cfg),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .chunk_offset (chunk_offset)
  );

endmodule
`default_nettype wire
